[src/nru_pvs_pkg.sv]
// Shared types and codes for the NRU page victim scanner.
// Depends on nothing; imported by nru_page_victim_scanner_core.
package nru_pvs_pkg;

  localparam int unsigned IDX_W   = 10;  // width of page index fields
  localparam int unsigned CLASS_W = 2;

  localparam logic [IDX_W-1:0] RESTART_RESET = 10'd512;
  localparam logic [IDX_W-1:0] POINTER_RESET = 10'd512;

  typedef enum logic [1:0] {
    MODE_INSTALL = 2'd0,
    MODE_REMOVE  = 2'd1,
    MODE_ACCESS  = 2'd2,
    MODE_SELECT  = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RMW   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  typedef struct packed {
    logic present;
    logic accessed;
    logic dirty;
  } entry_t;

endpackage

[src/nru_page_victim_scanner_core.sv]
// NRU page victim scanner: page-state table, scan pointer and victim search.
// Depends on nru_pvs_pkg for types, codes and reset values.
// Holds a present/accessed/dirty entry per page in a single-port-write,
// one-read memory. Each input word installs, removes or touches a page, or
// asks for a victim by the not-recently-used rule; each gives one output
// word. After reset a clearing pass writes every entry, during which no word
// is taken (restart writes are taken always). Install and remove write the
// page and register their output word when accepted; record access reads,
// then modifies and writes back, then hands on its result. Select visits
// one page per cycle through the registered memory read port, at most
// NUM_PAGES pages. The input stalls until the result is handed to the
// output register, which holds it while the output side stalls.
module nru_page_victim_scanner_core #(
  parameter int unsigned NUM_PAGES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // restart index write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nru_pvs_pkg::IDX_W-1:0] cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [nru_pvs_pkg::IDX_W-1:0] page_index_i,
  input  logic                          set_accessed_i,
  input  logic                          set_dirty_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [nru_pvs_pkg::IDX_W-1:0] victim_index_o,
  output logic [nru_pvs_pkg::CLASS_W-1:0] victim_class_o,
  output logic                          victim_found_o
);
  import nru_pvs_pkg::*;

  // PW indexes the table; SW also holds the 10-bit pointer reset value,
  // which may lie beyond a small table.
  localparam int unsigned PW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned SW  = (PW > IDX_W) ? PW : IDX_W;
  localparam int unsigned STW = $clog2(NUM_PAGES + 1);

  // page table memory
  entry_t mem [NUM_PAGES];
  logic            mem_we;
  logic [PW-1:0]   mem_wa;
  logic [PW-1:0]   mem_ra;
  entry_t          mem_wd;
  entry_t          rd_data_q;

  // bypass for a read of the entry written in the same cycle
  logic            fwd_q, fwd_d;
  entry_t          fwd_data_q;

  state_e          state_q, state_d;
  logic [PW-1:0]   clr_q, clr_d;
  logic [IDX_W-1:0] restart_q;
  logic [SW-1:0]   ptr_q, ptr_d;

  // held access operands
  logic [PW-1:0]   op_page_q, op_page_d;
  logic            op_acc_q, op_acc_d;
  logic            op_dirty_q, op_dirty_d;

  // scan pipeline: issue stage reads, eval stage compares and writes back
  logic [SW-1:0]   iss_page_q, iss_page_d;
  logic [PW-1:0]   ev_page_q, ev_page_d;
  logic            ev_vld_q, ev_vld_d;
  logic [2:0]      best_cls_q, best_cls_d;
  logic [PW-1:0]   best_page_q, best_page_d;
  logic [STW-1:0]  steps_q, steps_d;

  // pending result
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic [CLASS_W-1:0] res_cls_q, res_cls_d;
  logic               res_found_q, res_found_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [CLASS_W-1:0] out_cls_q, out_cls_d;
  logic               out_found_q, out_found_d;

  // combinational helpers
  logic            in_accept;
  logic            slot_free;
  logic [SW-1:0]   page_ext;
  logic            page_in_range;
  entry_t          ev_ent;
  logic [CLASS_W-1:0] ev_cls;
  logic            ev_take;
  logic [2:0]      nb_cls;
  logic [PW-1:0]   nb_page;
  logic [SW-1:0]   nb_page_ext;
  logic            scan_stop;

  function automatic logic [SW-1:0] next_page(input logic [SW-1:0] p,
                                              input logic [IDX_W-1:0] rst_idx);
    logic [SW:0] n;
    n = {1'b0, p} + (SW+1)'(1);
    if (32'(n) >= NUM_PAGES) begin
      if (32'(rst_idx) < NUM_PAGES) begin
        next_page = SW'(rst_idx);
      end else begin
        next_page = '0;
      end
    end else begin
      next_page = n[SW-1:0];
    end
  endfunction

  assign cfg_ready_o    = 1'b1;
  assign slot_free      = !out_valid_q || !out_stall_i;
  assign in_stall_o     = (state_q != ST_IDLE) || !slot_free;
  assign in_accept      = in_valid_i && !in_stall_o;
  assign page_ext       = SW'(page_index_i);
  assign page_in_range  = 32'(page_index_i) < NUM_PAGES;

  assign out_valid_o    = out_valid_q;
  assign victim_index_o = out_idx_q;
  assign victim_class_o = out_cls_q;
  assign victim_found_o = out_found_q;

  // eval stage: pick the first page of lowest class
  assign ev_ent      = fwd_q ? fwd_data_q : rd_data_q;
  assign ev_cls      = {ev_ent.accessed, ev_ent.dirty};
  assign ev_take     = ev_ent.present && ({1'b0, ev_cls} < best_cls_q);
  assign nb_cls      = ev_take ? {1'b0, ev_cls} : best_cls_q;
  assign nb_page     = ev_take ? ev_page_q : best_page_q;
  assign nb_page_ext = SW'(nb_page);
  assign steps_d     = (state_q == ST_SCAN && ev_vld_q) ? steps_q + STW'(1) : steps_q;
  assign scan_stop   = (SW'(ev_page_q) == ptr_q) || (nb_cls == 3'd0) ||
                       (32'(steps_d) == NUM_PAGES);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ptr_d       = ptr_q;
    op_page_d   = op_page_q;
    op_acc_d    = op_acc_q;
    op_dirty_d  = op_dirty_q;
    iss_page_d  = iss_page_q;
    ev_page_d   = ev_page_q;
    ev_vld_d    = 1'b0;
    best_cls_d  = best_cls_q;
    best_page_d = best_page_q;
    res_idx_d   = res_idx_q;
    res_cls_d   = res_cls_q;
    res_found_d = res_found_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_cls_d   = out_cls_q;
    out_found_d = out_found_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    mem_ra      = iss_page_q[PW-1:0];

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + PW'(1);
        if (32'(clr_q) == NUM_PAGES - 1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        mem_ra = page_ext[PW-1:0];
        if (in_accept) begin
          case (mode_e'(mode_i))
            MODE_INSTALL, MODE_REMOVE: begin
              mem_we = page_in_range;
              mem_wa = page_ext[PW-1:0];
              mem_wd = (mode_e'(mode_i) == MODE_INSTALL) ?
                       entry_t'{present: 1'b1, accessed: set_accessed_i,
                                dirty: set_dirty_i} : entry_t'('0);
              out_valid_d = 1'b1;
              out_idx_d   = ptr_q[IDX_W-1:0];
              out_cls_d   = '0;
              out_found_d = 1'b0;
            end
            MODE_ACCESS: begin
              if (page_in_range) begin
                // read now, merge and write back next cycle
                op_page_d  = page_ext[PW-1:0];
                op_acc_d   = set_accessed_i;
                op_dirty_d = set_dirty_i;
                state_d    = ST_RMW;
              end else begin
                out_valid_d = 1'b1;
                out_idx_d   = ptr_q[IDX_W-1:0];
                out_cls_d   = '0;
                out_found_d = 1'b0;
              end
            end
            default: begin
              // select: scan from the page after the pointer
              iss_page_d  = next_page(ptr_q, restart_q);
              best_cls_d  = 3'd4;
              best_page_d = ptr_q[PW-1:0];
              state_d     = ST_SCAN;
            end
          endcase
        end
      end

      ST_RMW: begin
        mem_we      = 1'b1;
        mem_wa      = op_page_q;
        mem_wd      = entry_t'{present: rd_data_q.present,
                               accessed: rd_data_q.accessed | op_acc_q,
                               dirty: rd_data_q.dirty | op_dirty_q};
        res_idx_d   = ptr_q[IDX_W-1:0];
        res_cls_d   = '0;
        res_found_d = 1'b0;
        state_d     = ST_DONE;
      end

      ST_SCAN: begin
        // issue the next read every cycle; a read past the stop is dropped
        iss_page_d = next_page(iss_page_q, restart_q);
        ev_page_d  = iss_page_q[PW-1:0];
        ev_vld_d   = 1'b1;
        if (ev_vld_q) begin
          if (ev_ent.present) begin
            // clear the accessed bit of every present page visited
            mem_we = 1'b1;
            mem_wa = ev_page_q;
            mem_wd = entry_t'{present: 1'b1, accessed: 1'b0, dirty: ev_ent.dirty};
          end
          best_cls_d  = nb_cls;
          best_page_d = nb_page;
          if (scan_stop) begin
            ev_vld_d = 1'b0;
            state_d  = ST_DONE;
            if (!nb_cls[2]) begin
              ptr_d       = nb_page_ext;
              res_idx_d   = nb_page_ext[IDX_W-1:0];
              res_cls_d   = nb_cls[CLASS_W-1:0];
              res_found_d = 1'b1;
            end else begin
              res_idx_d   = ptr_q[IDX_W-1:0];
              res_cls_d   = '0;
              res_found_d = 1'b0;
            end
          end
        end
      end

      ST_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_idx_q;
          out_cls_d   = res_cls_q;
          out_found_d = res_found_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign fwd_d = mem_we && (mem_wa == mem_ra);

  // page table: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q  <= mem[mem_ra];
    fwd_data_q <= mem_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      restart_q   <= RESTART_RESET;
      ptr_q       <= SW'(POINTER_RESET);
      ev_vld_q    <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ptr_q       <= ptr_d;
      ev_vld_q    <= ev_vld_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        restart_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_page_q   <= op_page_d;
    op_acc_q    <= op_acc_d;
    op_dirty_q  <= op_dirty_d;
    iss_page_q  <= iss_page_d;
    ev_page_q   <= ev_page_d;
    best_cls_q  <= best_cls_d;
    best_page_q <= best_page_d;
    steps_q     <= (state_q == ST_IDLE) ? '0 : steps_d;
    res_idx_q   <= res_idx_d;
    res_cls_q   <= res_cls_d;
    res_found_q <= res_found_d;
    out_idx_q   <= out_idx_d;
    out_cls_q   <= out_cls_d;
    out_found_q <= out_found_d;
  end

endmodule
